[hdl/hlfs_pkg.sv]
package hlfs_pkg;

    // Framing sizes
    localparam int HANDSHAKE_BYTES = 48;
    localparam int HEADER_BYTES    = 4;

    localparam int HS_CNT_W  = $clog2(HANDSHAKE_BYTES);
    localparam int HDR_CNT_W = $clog2(HEADER_BYTES);

    localparam logic [HS_CNT_W-1:0]  HS_LAST  = HS_CNT_W'(HANDSHAKE_BYTES - 1);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

    localparam int MAX_PAYLOAD_W = 31;
    localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 31'd1048576;

    // Input opcodes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_OPEN  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_ERROR = 2'd3;

    // Result kinds
    localparam logic [1:0] K_CHAR  = 2'd0;
    localparam logic [1:0] K_EOL   = 2'd1;
    localparam logic [1:0] K_START = 2'd2;
    localparam logic [1:0] K_FIN   = 2'd3;

    // Finish reasons
    localparam logic [1:0] FR_CLOSED  = 2'd0;
    localparam logic [1:0] FR_HS_FAIL = 2'd1;
    localparam logic [1:0] FR_BAD_LEN = 2'd2;
    localparam logic [1:0] FR_LINK    = 2'd3;

    // Characters
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_H  = 8'h48;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_C  = 8'h43;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HAND   = 2'd1,
        PH_STREAM = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] reason;
    } result_t;

    // Up to two results per input beat, in order r0 then r1
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    // Handshake signature check; positions outside the signature always match
    function automatic logic magic_match(logic [HS_CNT_W-1:0] pos, logic [7:0] b);
        logic ok;
        case (pos)
            HS_CNT_W'(4):  ok = (b == CH_O);
            HS_CNT_W'(5):  ok = (b == CH_H);
            HS_CNT_W'(6):  ok = (b == CH_O);
            HS_CNT_W'(7):  ok = (b == CH_S);
            HS_CNT_W'(9):  ok = (b == CH_H);
            HS_CNT_W'(10): ok = (b == CH_D);
            HS_CNT_W'(11): ok = (b == CH_C);
            default:       ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

[hdl/hlfs_core.sv]
module hlfs_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [1:0]                            opcode,
    input  logic [7:0]                            data_byte,
    input  logic [hlfs_pkg::MAX_PAYLOAD_W-1:0]    max_payload,
    output hlfs_pkg::push_t                       push
);

    hlfs_pkg::phase_t phase_reg, phase_next;
    logic [hlfs_pkg::HS_CNT_W-1:0]      hs_count_reg, hs_count_next;
    logic                               magic_ok_reg, magic_ok_next;
    logic [hlfs_pkg::HDR_CNT_W-1:0]     hdr_count_reg, hdr_count_next;
    logic [23:0]                        length_shift_reg, length_shift_next;
    logic [hlfs_pkg::MAX_PAYLOAD_W-1:0] remain_reg, remain_next;
    logic                               line_reg, line_next;

    logic        active;
    logic        do_clear;
    logic [31:0] frame_len;
    logic        bad_len;

    assign active    = (phase_reg == hlfs_pkg::PH_HAND) || (phase_reg == hlfs_pkg::PH_STREAM);
    assign frame_len = {length_shift_reg, data_byte};
    assign bad_len   = frame_len[31] || (frame_len[30:0] > max_payload);

    // Per-beat state update and result generation
    always_comb
    begin
        phase_next        = phase_reg;
        hs_count_next     = hs_count_reg;
        magic_ok_next     = magic_ok_reg;
        hdr_count_next    = hdr_count_reg;
        length_shift_next = length_shift_reg;
        remain_next       = remain_reg;
        line_next         = line_reg;
        do_clear          = 1'b0;
        push              = '0;

        if (accept)
        begin
            unique case (opcode)
                hlfs_pkg::OP_OPEN:
                begin
                    if (!active)
                    begin
                        do_clear   = 1'b1;
                        phase_next = hlfs_pkg::PH_HAND;
                    end
                end
                hlfs_pkg::OP_CLOSE:
                begin
                    // end of line first, then finished
                    push.v0        = line_reg || active;
                    push.v1        = line_reg && active;
                    push.r0.kind   = line_reg ? hlfs_pkg::K_EOL : hlfs_pkg::K_FIN;
                    push.r0.reason = hlfs_pkg::FR_CLOSED;
                    push.r1.kind   = hlfs_pkg::K_FIN;
                    push.r1.reason = hlfs_pkg::FR_CLOSED;
                    line_next      = 1'b0;
                    if (active)
                    begin
                        do_clear   = 1'b1;
                        phase_next = hlfs_pkg::PH_IDLE;
                    end
                end
                hlfs_pkg::OP_ERROR:
                begin
                    if (active)
                    begin
                        push.v0        = 1'b1;
                        push.r0.kind   = hlfs_pkg::K_FIN;
                        push.r0.reason = hlfs_pkg::FR_LINK;
                        do_clear       = 1'b1;
                        phase_next     = hlfs_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    if (phase_reg == hlfs_pkg::PH_HAND)
                    begin
                        // handshake byte
                        magic_ok_next = magic_ok_reg
                                        && hlfs_pkg::magic_match(hs_count_reg, data_byte);
                        hs_count_next = hs_count_reg + 1'b1;
                        if (hs_count_reg == hlfs_pkg::HS_LAST)
                        begin
                            push.v0 = 1'b1;
                            if (magic_ok_next)
                            begin
                                hs_count_next = '0;
                                phase_next    = hlfs_pkg::PH_STREAM;
                                push.r0.kind  = hlfs_pkg::K_START;
                            end
                            else
                            begin
                                push.r0.kind   = hlfs_pkg::K_FIN;
                                push.r0.reason = hlfs_pkg::FR_HS_FAIL;
                                do_clear       = 1'b1;
                                phase_next     = hlfs_pkg::PH_IDLE;
                            end
                        end
                    end
                    else if (phase_reg == hlfs_pkg::PH_STREAM)
                    begin
                        if (remain_reg == '0)
                        begin
                            // length header byte, big-endian
                            length_shift_next = {length_shift_reg[15:0], data_byte};
                            hdr_count_next    = hdr_count_reg + 1'b1;
                            if (hdr_count_reg == hlfs_pkg::HDR_LAST)
                            begin
                                hdr_count_next    = '0;
                                length_shift_next = '0;
                                if (frame_len != '0)
                                begin
                                    if (bad_len)
                                    begin
                                        push.v0        = 1'b1;
                                        push.r0.kind   = hlfs_pkg::K_FIN;
                                        push.r0.reason = hlfs_pkg::FR_BAD_LEN;
                                        do_clear       = 1'b1;
                                        phase_next     = hlfs_pkg::PH_IDLE;
                                    end
                                    else
                                    begin
                                        remain_next = frame_len[30:0];
                                    end
                                end
                            end
                        end
                        else
                        begin
                            // payload byte
                            remain_next = remain_reg - 1'b1;
                            if (data_byte == hlfs_pkg::CH_LF)
                            begin
                                if (line_reg)
                                begin
                                    line_next    = 1'b0;
                                    push.v0      = 1'b1;
                                    push.r0.kind = hlfs_pkg::K_EOL;
                                end
                            end
                            else
                            begin
                                line_next    = 1'b1;
                                push.v0      = 1'b1;
                                push.r0.kind = hlfs_pkg::K_CHAR;
                                push.r0.data = data_byte;
                            end
                        end
                    end
                end
            endcase
        end

        // session clear on open or finish
        if (do_clear)
        begin
            hs_count_next     = '0;
            magic_ok_next     = 1'b1;
            hdr_count_next    = '0;
            length_shift_next = '0;
            remain_next       = '0;
            line_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= hlfs_pkg::PH_IDLE;
            hs_count_reg     <= '0;
            magic_ok_reg     <= 1'b1;
            hdr_count_reg    <= '0;
            length_shift_reg <= '0;
            remain_reg       <= '0;
            line_reg         <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            hs_count_reg     <= hs_count_next;
            magic_ok_reg     <= magic_ok_next;
            hdr_count_reg    <= hdr_count_next;
            length_shift_reg <= length_shift_next;
            remain_reg       <= remain_next;
            line_reg         <= line_next;
        end
    end

endmodule

[hdl/hlfs_outq.sv]
module hlfs_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  hlfs_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output hlfs_pkg::result_t out_res
);

    // Four-entry result queue; takes up to two results and gives one per cycle while out_ready is high
    hlfs_pkg::result_t mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] push_n;
    logic [1:0] wr_ptr_p1;

    assign room      = (count_reg <= 3'd2);
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign push_n    = {1'b0, push.v0} + {1'b0, push.v1};
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'b0, pop};
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/handshake_length_frame_line_splitter.sv]
// Receive-side deframer for a byte link.
// Input channel (in_valid/in_ready): one beat per link event, opcode selects
// byte, open, close or link error; data_byte is used for byte beats only.
// Output channel (out_valid/out_ready): one result per beat: kind, the line
// character in data_byte_res, and finish_reason for finished results.
// Config channel (cfg_valid/cfg_ready): writes max_payload; always ready,
// write only while the block is idle.
// After open, a 48-byte handshake is checked, then length-prefixed frames
// are parsed and their payload leaves as line characters and end-of-line.
// Each result is registered in the output queue and offered from there.
// The block takes one input beat per cycle while in_ready is high; a close
// that ends a started line yields two results, which leave one at a time.
// Results sit in a four-entry queue; in_ready drops while fewer than two
// entries are free, so a stalled receiver backs up into the input channel
// without losing results.
// Reset: idle phase, queue empty, max_payload = 1048576.
module handshake_length_frame_line_splitter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         opcode,
    input  logic [7:0]                         data_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         kind,
    output logic [7:0]                         data_byte_res,
    output logic [1:0]                         finish_reason,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hlfs_pkg::MAX_PAYLOAD_W-1:0] cfg_max_payload
);

    logic [hlfs_pkg::MAX_PAYLOAD_W-1:0] max_payload_reg;
    logic                               accept;
    logic                               room;
    hlfs_pkg::push_t                    push;
    hlfs_pkg::result_t                  out_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = room;
    assign accept    = in_valid && room;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= hlfs_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_payload_reg <= cfg_max_payload;
        end
    end

    hlfs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (opcode),
        .data_byte   (data_byte),
        .max_payload (max_payload_reg),
        .push        (push)
    );

    hlfs_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind          = out_res.kind;
    assign data_byte_res = out_res.data;
    assign finish_reason = out_res.reason;

endmodule
